### rtl/mlfq_pkg.sv
// Package for the multilevel feedback queue scheduler.
// Holds sizes, action and status codes, and the lottery level decode.
// No dependencies.
package mlfq_pkg;

  localparam int NumLevels = 6;
  localparam int MaxTasks = 64;
  localparam int TaskW = 6;
  localparam int LevelW = 3;
  localparam int SliceW = 13;
  localparam int CountW = 7;
  localparam int QuantW = 8;
  localparam logic [SliceW-1:0] SliceMax = 13'h1fff;

  localparam logic [1:0] ActEnqueue = 2'd0;
  localparam logic [1:0] ActDequeue = 2'd1;
  localparam logic [1:0] ActPick = 2'd2;
  localparam logic [1:0] ActTick = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StMisuse = 2'd2;

  localparam int TaskMemW = LevelW + SliceW + 1;
  localparam int LinkMemW = 2 * TaskW;

  function automatic logic [LevelW-1:0] draw_level(input logic [5:0] p);
    logic [LevelW-1:0] lv;
    lv = LevelW'(NumLevels - 1);
    if (p < 6'd32) lv = 3'd0;
    else if (p < 6'd48) lv = 3'd1;
    else if (p < 6'd56) lv = 3'd2;
    else if (p < 6'd60) lv = 3'd3;
    else if (p < 6'd62) lv = 3'd4;
    else if (p < 6'd63) lv = 3'd5;
    return lv;
  endfunction

  function automatic logic [SliceW-1:0] quantum(input logic [QuantW-1:0] q,
                                                input logic [LevelW-1:0] lv);
    logic [QuantW+7:0] s;
    s = {8'd0, q} << lv;
    return (s > {3'd0, SliceMax}) ? SliceMax : s[SliceW-1:0];
  endfunction

endpackage

### rtl/mlfq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mlfq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/multilevel_feedback_queue_scheduler.sv
// Top level of the multilevel feedback queue scheduler.
// Depends on mlfq_pkg and mlfq_ram.
//
// Usage: one input word (action, task id, lottery) produces one output word
// (status, picked task, level, slice, resched, queued total). Both channels
// use valid and stall. The user must write the base quantum register
// (cfg_we_i) only while the block is idle; the block does not enforce it.
// Per-task level, slice and queued flag live in one RAM; the list links in
// a second RAM. Level heads, tails and counts are flip-flops.
// After reset a clearing pass writes zeros over every task RAM entry, one
// entry a cycle; no input word is accepted meanwhile.
// An item goes through a sequencer: read task entry, then for enqueue read
// the tail's links, for dequeue read the neighbors' links one at a time,
// then write back and present the result. Pick, tick and a rejected enqueue
// or dequeue pass SRead, SExec and SDone; enqueue and dequeue also pass
// SLinkA and SLinkB. The result word is registered after SDone. One item is
// in flight at a time; the next is accepted the cycle after the result is
// taken, and a stalled output holds the word and blocks the input.
module multilevel_feedback_queue_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mlfq_pkg::QuantW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [mlfq_pkg::TaskW-1:0]    task_id_i,
  input  logic [5:0]                    lottery_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [mlfq_pkg::TaskW-1:0]    picked_task_o,
  output logic [mlfq_pkg::LevelW-1:0]   task_level_o,
  output logic [mlfq_pkg::SliceW-1:0]   slice_left_o,
  output logic                          resched_o,
  output logic [mlfq_pkg::CountW-1:0]   queued_total_o
);

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle = 3'd1;
  localparam logic [2:0] SRead = 3'd2;
  localparam logic [2:0] SExec = 3'd3;
  localparam logic [2:0] SLinkA = 3'd4;
  localparam logic [2:0] SLinkB = 3'd5;
  localparam logic [2:0] SDone = 3'd6;

  localparam int TW = mlfq_pkg::TaskW;
  localparam int LW = mlfq_pkg::LevelW;
  localparam int SW = mlfq_pkg::SliceW;
  localparam int CW = mlfq_pkg::CountW;

  logic [2:0] state_q, state_d;
  logic [TW-1:0] clr_q, clr_d;
  logic [mlfq_pkg::QuantW-1:0] quant_q;
  logic [1:0] act_q, act_d;
  logic [TW-1:0] tid_q, tid_d;
  logic [5:0] lot_q, lot_d;
  logic [LW-1:0] lv_q, lv_d;
  logic [TW-1:0] nx_q, nx_d, pv_q, pv_d;
  logic [TW-1:0] head_q [mlfq_pkg::NumLevels];
  logic [TW-1:0] tail_q [mlfq_pkg::NumLevels];
  logic [CW-1:0] cnt_q [mlfq_pkg::NumLevels];
  logic [TW-1:0] head_d [mlfq_pkg::NumLevels];
  logic [TW-1:0] tail_d [mlfq_pkg::NumLevels];
  logic [CW-1:0] cnt_d [mlfq_pkg::NumLevels];
  logic [CW-1:0] total_q, total_d;

  logic out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [TW-1:0] picked_q, picked_d;
  logic [LW-1:0] olv_q, olv_d;
  logic [SW-1:0] osl_q, osl_d;
  logic resched_q, resched_d;

  logic t_we;
  logic [TW-1:0] t_waddr, t_raddr;
  logic [mlfq_pkg::TaskMemW-1:0] t_wdata, t_rdata;
  logic l_we;
  logic [TW-1:0] l_waddr, l_raddr;
  logic [mlfq_pkg::LinkMemW-1:0] l_wdata, l_rdata;

  logic in_acc;
  logic [LW-1:0] pick_lv;
  logic pick_found;

  mlfq_ram #(.Width(mlfq_pkg::TaskMemW), .Depth(mlfq_pkg::MaxTasks)) u_task_ram (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  mlfq_ram #(.Width(mlfq_pkg::LinkMemW), .Depth(mlfq_pkg::MaxTasks)) u_link_ram (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(l_raddr), .rdata_o(l_rdata)
  );

  assign in_stall_o = (state_q != SIdle) || out_valid_q;
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    logic [LW-1:0] d;
    d = mlfq_pkg::draw_level(lot_q);
    pick_lv = d;
    pick_found = (cnt_q[d] != '0);
    for (int i = mlfq_pkg::NumLevels - 1; i >= 0; i--) begin
      if (!pick_found || pick_lv != d) begin
        if (cnt_q[i] != '0 && !(cnt_q[d] != '0)) begin
          pick_lv = LW'(i);
        end
      end
    end
    if (cnt_q[d] == '0) begin
      pick_found = 1'b0;
      for (int i = 0; i < mlfq_pkg::NumLevels; i++) begin
        if (cnt_q[i] != '0) begin
          pick_found = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic queued;
    logic [LW-1:0] nlv;
    state_d = state_q;
    clr_d = clr_q;
    act_d = act_q;
    tid_d = tid_q;
    lot_d = lot_q;
    lv_d = lv_q;
    nx_d = nx_q;
    pv_d = pv_q;
    head_d = head_q;
    tail_d = tail_q;
    cnt_d = cnt_q;
    total_d = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d = status_q;
    picked_d = picked_q;
    olv_d = olv_q;
    osl_d = osl_q;
    resched_d = resched_q;
    t_we = 1'b0;
    t_waddr = tid_q;
    t_wdata = '0;
    t_raddr = tid_q;
    l_we = 1'b0;
    l_waddr = tid_q;
    l_wdata = '0;
    l_raddr = tid_q;
    queued = t_rdata[0];
    nlv = '0;

    unique case (state_q)
      SClear: begin
        t_we = 1'b1;
        t_waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == TW'(mlfq_pkg::MaxTasks - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_acc) begin
          act_d = action_i;
          tid_d = task_id_i;
          lot_d = lottery_i;
          state_d = SRead;
        end
      end
      SRead: begin
        // Pick reads the head entry; others read the addressed task.
        if (act_q == mlfq_pkg::ActPick) begin
          t_raddr = head_q[pick_lv];
          tid_d = head_q[pick_lv];
        end
        l_raddr = (act_q == mlfq_pkg::ActPick) ? head_q[pick_lv] : tid_q;
        state_d = SExec;
      end
      SExec: begin
        lv_d = t_rdata[mlfq_pkg::TaskMemW-1 -: LW];
        nx_d = l_rdata[2*TW-1:TW];
        pv_d = l_rdata[TW-1:0];
        status_d = mlfq_pkg::StOk;
        picked_d = '0;
        resched_d = 1'b0;
        olv_d = t_rdata[mlfq_pkg::TaskMemW-1 -: LW];
        osl_d = t_rdata[SW:1];
        state_d = SDone;
        unique case (act_q)
          mlfq_pkg::ActPick: begin
            if (pick_found) begin
              picked_d = tid_q;
            end else begin
              status_d = mlfq_pkg::StEmpty;
              olv_d = '0;
              osl_d = '0;
            end
          end
          mlfq_pkg::ActTick: begin
            if (t_rdata[SW:1] != '0) begin
              osl_d = t_rdata[SW:1] - 1'b1;
            end
            resched_d = (t_rdata[SW:1] <= SW'(1));
            t_we = 1'b1;
            t_wdata = {t_rdata[mlfq_pkg::TaskMemW-1 -: LW],
                       (t_rdata[SW:1] != '0) ? t_rdata[SW:1] - 1'b1 : t_rdata[SW:1],
                       queued};
          end
          mlfq_pkg::ActEnqueue: begin
            if (queued) begin
              status_d = mlfq_pkg::StMisuse;
            end else begin
              nlv = t_rdata[mlfq_pkg::TaskMemW-1 -: LW];
              if (t_rdata[SW:1] == '0 && nlv < LW'(mlfq_pkg::NumLevels - 1)) begin
                nlv = nlv + 1'b1;
              end
              lv_d = nlv;
              olv_d = nlv;
              osl_d = mlfq_pkg::quantum(quant_q, nlv);
              t_we = 1'b1;
              t_wdata = {nlv, mlfq_pkg::quantum(quant_q, nlv), 1'b1};
              l_raddr = tail_q[nlv];
              total_d = total_q + 1'b1;
              state_d = SLinkA;
            end
          end
          default: begin
            if (!queued) begin
              status_d = mlfq_pkg::StMisuse;
            end else begin
              t_we = 1'b1;
              t_wdata = {t_rdata[mlfq_pkg::TaskMemW-1 -: LW], t_rdata[SW:1], 1'b0};
              l_raddr = l_rdata[TW-1:0];
              total_d = total_q - 1'b1;
              state_d = SLinkA;
            end
          end
        endcase
      end
      SLinkA: begin
        if (act_q == mlfq_pkg::ActEnqueue) begin
          if (cnt_q[lv_q] == '0) begin
            head_d[lv_q] = tid_q;
          end else begin
            l_we = 1'b1;
            l_waddr = tail_q[lv_q];
            l_wdata = {tid_q, l_rdata[TW-1:0]};
            // The new task's prev link is written next cycle.
          end
          state_d = SLinkB;
        end else begin
          if (head_q[lv_q] == tid_q) begin
            head_d[lv_q] = nx_q;
          end else begin
            l_we = 1'b1;
            l_waddr = pv_q;
            l_wdata = {nx_q, l_rdata[TW-1:0]};
          end
          l_raddr = nx_q;
          state_d = SLinkB;
        end
      end
      SLinkB: begin
        if (act_q == mlfq_pkg::ActEnqueue) begin
          if (cnt_q[lv_q] != '0) begin
            l_we = 1'b1;
            l_waddr = tid_q;
            l_wdata = {nx_q, tail_q[lv_q]};
          end
          tail_d[lv_q] = tid_q;
          cnt_d[lv_q] = cnt_q[lv_q] + 1'b1;
        end else begin
          if (tail_q[lv_q] == tid_q) begin
            tail_d[lv_q] = pv_q;
          end else begin
            l_we = 1'b1;
            l_waddr = nx_q;
            // Forward the next-link written last cycle when nx equals pv.
            l_wdata = {((nx_q == pv_q) && (head_q[lv_q] != tid_q)) ? nx_q
                       : l_rdata[2*TW-1:TW], pv_q};
          end
          if (cnt_q[lv_q] != '0) begin
            cnt_d[lv_q] = cnt_q[lv_q] - 1'b1;
          end
        end
        state_d = SDone;
      end
      SDone: begin
        out_valid_d = 1'b1;
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q <= '0;
      quant_q <= mlfq_pkg::QuantW'(5);
      total_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < mlfq_pkg::NumLevels; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      total_q <= total_d;
      out_valid_q <= out_valid_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        quant_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    tid_q <= tid_d;
    lot_q <= lot_d;
    lv_q <= lv_d;
    nx_q <= nx_d;
    pv_q <= pv_d;
    head_q <= head_d;
    tail_q <= tail_d;
    status_q <= status_d;
    picked_q <= picked_d;
    olv_q <= olv_d;
    osl_q <= osl_d;
    resched_q <= resched_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign picked_task_o = picked_q;
  assign task_level_o = olv_q;
  assign slice_left_o = osl_q;
  assign resched_o = resched_q;
  assign queued_total_o = total_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !in_acc) else $error("input accepted while busy");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(mlfq_pkg::MaxTasks)) else $error("queued total overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q) else $error("result dropped");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDone) |=> out_valid_q) else $error("result not shown");

endmodule

### tb/sv/multilevel_feedback_queue_scheduler_test.sv
`timescale 1ns / 100ps
// Testbench for multilevel_feedback_queue_scheduler: directed and random words
// are checked against a behavioral run-queue predictor. Also depends on mlfq_pkg.
module multilevel_feedback_queue_scheduler_test;

  typedef struct packed {
    logic [1:0]                  status;
    logic [mlfq_pkg::TaskW-1:0]  picked;
    logic [mlfq_pkg::LevelW-1:0] level;
    logic [mlfq_pkg::SliceW-1:0] slice;
    logic                        resched;
    logic [mlfq_pkg::CountW-1:0] total;
  } sched_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mlfq_pkg::QuantW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] action_i = mlfq_pkg::ActEnqueue;
  logic [mlfq_pkg::TaskW-1:0] task_id_i = '0;
  logic [5:0] lottery_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [mlfq_pkg::TaskW-1:0] picked_task_o;
  logic [mlfq_pkg::LevelW-1:0] task_level_o;
  logic [mlfq_pkg::SliceW-1:0] slice_left_o;
  logic resched_o;
  logic [mlfq_pkg::CountW-1:0] queued_total_o;

  multilevel_feedback_queue_scheduler u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state.
  logic [mlfq_pkg::LevelW-1:0] lvl_of[mlfq_pkg::MaxTasks];
  logic [mlfq_pkg::SliceW-1:0] slc_of[mlfq_pkg::MaxTasks];
  logic                        is_queued[mlfq_pkg::MaxTasks];
  int                          run_q[mlfq_pkg::NumLevels][$];
  int                          total_queued;
  logic [mlfq_pkg::QuantW-1:0] quantum_reg;

  sched_word_t expected_words[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_gaps = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int pick_level(input int p);
    int bound, weight;
    bound = 0;
    weight = 32;
    for (int lv = 0; lv < mlfq_pkg::NumLevels; lv++) begin
      bound += weight;
      if (p < bound) return lv;
      weight >>= 1;
    end
    return mlfq_pkg::NumLevels - 1;
  endfunction

  function automatic sched_word_t schedule_step(input logic [1:0] act, input int t,
                                                input int lot);
    sched_word_t r;
    int lv, s, idx;
    r = '0;
    case (act)
      mlfq_pkg::ActPick: begin
        lv = pick_level(lot);
        if (run_q[lv].size() == 0) begin
          lv = -1;
          for (int i = 0; i < mlfq_pkg::NumLevels; i++)
            if (lv < 0 && run_q[i].size() != 0) lv = i;
        end
        if (lv < 0) begin
          r.status = mlfq_pkg::StEmpty;
        end else begin
          r.picked = mlfq_pkg::TaskW'(run_q[lv][0]);
          r.level = lvl_of[run_q[lv][0]];
          r.slice = slc_of[run_q[lv][0]];
        end
      end
      mlfq_pkg::ActEnqueue: begin
        if (is_queued[t]) begin
          r.status = mlfq_pkg::StMisuse;
        end else begin
          lv = int'(lvl_of[t]);
          if (slc_of[t] == 0 && lv < mlfq_pkg::NumLevels - 1) lv++;
          lvl_of[t] = mlfq_pkg::LevelW'(lv);
          s = int'(quantum_reg) << lv;
          if (s > 8191) s = 8191;
          slc_of[t] = mlfq_pkg::SliceW'(s);
          run_q[lv].push_back(t);
          is_queued[t] = 1'b1;
          total_queued++;
        end
        r.level = lvl_of[t];
        r.slice = slc_of[t];
      end
      mlfq_pkg::ActDequeue: begin
        if (!is_queued[t]) begin
          r.status = mlfq_pkg::StMisuse;
        end else begin
          lv = int'(lvl_of[t]);
          idx = -1;
          for (int i = 0; i < run_q[lv].size(); i++) if (run_q[lv][i] == t) idx = i;
          run_q[lv].delete(idx);
          is_queued[t] = 1'b0;
          total_queued--;
        end
        r.level = lvl_of[t];
        r.slice = slc_of[t];
      end
      default: begin
        if (slc_of[t] > 0) slc_of[t]--;
        r.resched = (slc_of[t] == 0);
        r.level = lvl_of[t];
        r.slice = slc_of[t];
      end
    endcase
    r.total = mlfq_pkg::CountW'(total_queued);
    return r;
  endfunction

  task automatic send_word(input logic [1:0] act, input int t, input int lot);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    task_id_i <= mlfq_pkg::TaskW'(t);
    lottery_i <= 6'(lot);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_words.push_back(schedule_step(act, t, lot));
  endtask

  // Receiver stall and result checking.
  initial begin
    int wait_n;
    wait_n = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          sched_word_t e;
          e = expected_words.pop_front();
          if (status_o !== e.status)
            report_mismatch("status", int'(status_o), int'(e.status));
          if (picked_task_o !== e.picked)
            report_mismatch("picked_task", int'(picked_task_o), int'(e.picked));
          if (task_level_o !== e.level)
            report_mismatch("task_level", int'(task_level_o), int'(e.level));
          if (slice_left_o !== e.slice)
            report_mismatch("slice_left", int'(slice_left_o), int'(e.slice));
          if (resched_o !== e.resched)
            report_mismatch("resched", int'(resched_o), int'(e.resched));
          if (queued_total_o !== e.total)
            report_mismatch("queued_total", int'(queued_total_o), int'(e.total));
        end
        wait_n = no_gaps ? 0 : $urandom_range(0, 11);
        out_stall_i <= (wait_n != 0);
      end else if (out_stall_i) begin
        wait_n--;
        out_stall_i <= (wait_n > 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_quantum(input logic [mlfq_pkg::QuantW-1:0] q);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= q;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    quantum_reg = q;
  endtask

  task automatic test_directed();
    send_word(mlfq_pkg::ActPick, 0, 0);
    send_word(mlfq_pkg::ActDequeue, 63, 63);
    send_word(mlfq_pkg::ActEnqueue, 0, 0);
    send_word(mlfq_pkg::ActEnqueue, 0, 0);
    send_word(mlfq_pkg::ActEnqueue, 63, 63);
    send_word(mlfq_pkg::ActEnqueue, 21, 42);
    send_word(mlfq_pkg::ActPick, 0, 62);
    send_word(mlfq_pkg::ActPick, 0, 63);
    send_word(mlfq_pkg::ActPick, 0, 31);
    send_word(mlfq_pkg::ActTick, 63, 0);
    send_word(mlfq_pkg::ActDequeue, 63, 0);
    send_word(mlfq_pkg::ActDequeue, 0, 0);
    repeat (6) send_word(mlfq_pkg::ActTick, 42, 21);
    send_word(mlfq_pkg::ActEnqueue, 42, 0);
    send_word(mlfq_pkg::ActDequeue, 21, 0);
    send_word(mlfq_pkg::ActDequeue, 42, 0);
    send_word(mlfq_pkg::ActPick, 0, 48);
  endtask

  task automatic test_random(input int n);
    int r, t;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      t = $urandom_range(0, 15) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 11);
      if (r < 3) send_word(mlfq_pkg::ActEnqueue, t, $urandom_range(0, 63));
      else if (r < 5) send_word(mlfq_pkg::ActDequeue, t, $urandom_range(0, 63));
      else if (r < 7)
        send_word(mlfq_pkg::ActPick, $urandom_range(0, 63), $urandom_range(0, 63));
      else send_word(mlfq_pkg::ActTick, t, $urandom_range(0, 63));
    end
  endtask

  task automatic test_fill_all();
    no_gaps = 1;
    for (int t = 0; t < mlfq_pkg::MaxTasks; t++) send_word(mlfq_pkg::ActEnqueue, t, 0);
    for (int t = 0; t < 64; t++) send_word(mlfq_pkg::ActPick, 0, t);
    for (int t = 0; t < mlfq_pkg::MaxTasks; t += 2) send_word(mlfq_pkg::ActDequeue, t, 0);
    no_gaps = 0;
  endtask

  initial begin
    for (int i = 0; i < mlfq_pkg::MaxTasks; i++) begin
      lvl_of[i] = '0;
      slc_of[i] = '0;
      is_queued[i] = 1'b0;
    end
    total_queued = 0;
    quantum_reg = 8'd5;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    write_quantum(8'd255);
    test_fill_all();
    test_random(220);
    drain_results();
    send_word(mlfq_pkg::ActPick, 0, 0);
    write_quantum(8'd1);
    test_random(220);
    write_quantum(8'($urandom_range(2, 254)));
    test_random(220);
    drain_results();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### multilevel_feedback_queue_scheduler.f
rtl/mlfq_pkg.sv
rtl/mlfq_ram.sv
rtl/multilevel_feedback_queue_scheduler.sv
tb/sv/multilevel_feedback_queue_scheduler_test.sv
